@@ hw/rtl/rtbc_pkg.sv @@
// Shared types, constants and decode functions for the ranging timing budget calculator.
// Used by rtbc_div, ranging_timing_budget_calc and rtbc_checker; depends on nothing.
package rtbc_pkg;

  localparam int unsigned MacW   = 20;  // macro period in ns, at most 968532
  localparam int unsigned WordW  = 32;

  localparam logic [31:0] OvhStart = 32'd1910;
  localparam logic [31:0] OvhEnd   = 32'd960;
  localparam logic [31:0] OvhMsrc  = 32'd660;
  localparam logic [31:0] OvhTcc   = 32'd590;
  localparam logic [31:0] OvhDss   = 32'd690;
  localparam logic [31:0] OvhPre   = 32'd660;
  localparam logic [31:0] OvhFinal = 32'd550;
  localparam logic [31:0] RoundHalf = 32'd500;

  // ceil(2^40 / 1000); exact floor(x / 1000) for every 32-bit x after >> 40.
  localparam logic [30:0] Recip1000 = 31'd1099511628;

  localparam logic [1:0] StatusWritten  = 2'd0;
  localparam logic [1:0] StatusDisabled = 2'd1;
  localparam logic [1:0] StatusTooSmall = 2'd2;

  typedef struct packed {
    logic [7:0]  sequence_enables;
    logic [7:0]  pre_period_code;
    logic [7:0]  final_period_code;
    logic [7:0]  msrc_timeout_code;
    logic [15:0] pre_timeout_code;
    logic [15:0] final_timeout_code;
    logic [31:0] requested_budget_us;
  } item_t;

  typedef struct packed {
    logic [31:0] current_budget_us;
    logic [15:0] new_final_code;
    logic [1:0]  set_status;
  } result_t;

  // Fields that ride alongside a division through the divider pipeline.
  typedef struct packed {
    logic [31:0] cur;
    logic [1:0]  status;
    logic [15:0] pre_add;
  } div_side_t;

  // Pulse period: ((code + 1) * 2) mod 256.
  function automatic logic [7:0] period_of(logic [7:0] code);
    logic [8:0] dbl;
    dbl = {code, 1'b0};
    return 8'(dbl + 9'd2);
  endfunction

  // Macro period in ns: (3813120 * p + 500) / 1000 = 3813 * p + (12 * p + 50) / 100.
  function automatic logic [MacW-1:0] macro_ns(logic [7:0] p);
    logic [MacW-1:0] whole;
    logic [11:0]     y;
    logic [22:0]     z;
    whole = MacW'(p) * MacW'(3813);
    y     = 12'(p) * 12'd12 + 12'd50;
    z     = 23'(y) * 23'd1311;
    return whole + MacW'(z[22:17]);
  endfunction

  // Timeout decode: ((mantissa << exponent) mod 2^16) + 1, mod 2^16.
  function automatic logic [15:0] decode_to(logic [15:0] code);
    logic [15:0] v;
    if (code[15:8] >= 8'd16) begin
      v = 16'd0;
    end else begin
      v = 16'({8'd0, code[7:0]} << code[11:8]);
    end
    return v + 16'd1;
  endfunction

endpackage

@@ hw/rtl/rtbc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, 32 stages.
// Depends on rtbc_pkg for the word widths and the sideband struct.
module rtbc_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [31:0]             dividend_i,
  input  logic [19:0]             divisor_i,
  input  rtbc_pkg::div_side_t     side_i,
  output logic                    out_valid_o,
  output logic [31:0]             quotient_o,
  output rtbc_pkg::div_side_t     side_o
);
  import rtbc_pkg::*;

  localparam int unsigned Steps = WordW;

  typedef struct packed {
    logic [MacW-1:0]  rem;
    logic [WordW-1:0] dq;   // dividend bits shift out the top, quotient bits in the bottom
    logic [MacW-1:0]  dvs;
    div_side_t        side;
  } stage_t;

  stage_t st_q  [1:Steps];
  logic   vld_q [1:Steps];
  stage_t st_in;

  // A zero divisor always passes the trial, so the quotient comes out all ones.
  function automatic stage_t div_step(stage_t s);
    logic [MacW:0] trial;
    stage_t        r;
    r     = s;
    trial = {s.rem, s.dq[WordW-1]};
    if (trial >= {1'b0, s.dvs}) begin
      r.rem = MacW'(trial - {1'b0, s.dvs});
      r.dq  = {s.dq[WordW-2:0], 1'b1};
    end else begin
      r.rem = trial[MacW-1:0];
      r.dq  = {s.dq[WordW-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    st_in.rem  = '0;
    st_in.dq   = dividend_i;
    st_in.dvs  = divisor_i;
    st_in.side = side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= Steps; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[1] <= in_valid_i;
      for (int k = 2; k <= Steps; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[1] <= div_step(st_in);
    for (int k = 2; k <= Steps; k++) st_q[k] <= div_step(st_q[k-1]);
  end

  assign out_valid_o = vld_q[Steps];
  assign quotient_o  = st_q[Steps].dq;
  assign side_o      = st_q[Steps].side;

endmodule

@@ hw/rtl/ranging_timing_budget_calc.sv @@
// Ranging sensor timing budget calculator: current budget and new final-range timeout code.
// A transaction passes stages 1 to 5, the divider and stages 38 and 39 before done_o.
// Throughput: one transaction per cycle; busy is tied low since results cannot be held off.
// The rate is set by the 32-stage divider pipeline, which takes a new division every cycle.
// Reset (rst_ni, asynchronous, active low) clears every valid bit; no results are in flight.
// Depends on rtbc_pkg and rtbc_div.
module ranging_timing_budget_calc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rtbc_pkg::item_t   item_i,
  output logic              done_o,
  output rtbc_pkg::result_t result_o
);
  import rtbc_pkg::*;

  // The pipeline never stalls, so a new transaction is always welcome.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage 1: decode pulse periods into macro periods and timeout codes into
  // macro clock counts. When pre-range is enabled the final-range count holds
  // pre-range too, so pre-range is taken out (wrapping mod 2^16).
  // ---------------------------------------------------------------------------
  logic              v1_q;
  logic [7:0]        en1_q;
  logic [MacW-1:0]   mac_pre1_q, mac_fin1_q;
  logic [8:0]        msrc_mclks1_q;
  logic [15:0]       pre_mclks1_q, fin_mclks1_q;
  logic [31:0]       req1_q;

  logic [15:0] pre_mclks_d, fin_raw_d;
  assign pre_mclks_d = decode_to(item_i.pre_timeout_code);
  assign fin_raw_d   = decode_to(item_i.final_timeout_code);

  always_ff @(posedge clk_i) begin
    en1_q         <= item_i.sequence_enables;
    mac_pre1_q    <= macro_ns(period_of(item_i.pre_period_code));
    mac_fin1_q    <= macro_ns(period_of(item_i.final_period_code));
    msrc_mclks1_q <= {1'b0, item_i.msrc_timeout_code} + 9'd1;
    pre_mclks1_q  <= pre_mclks_d;
    fin_mclks1_q  <= item_i.sequence_enables[6] ? (fin_raw_d - pre_mclks_d) : fin_raw_d;
    req1_q        <= item_i.requested_budget_us;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: macro clocks times macro period plus rounding, all mod 2^32.
  // ---------------------------------------------------------------------------
  logic              v2_q;
  logic [7:0]        en2_q;
  logic [MacW-1:0]   mac_fin2_q;
  logic [15:0]       pre_mclks2_q;
  logic [31:0]       req2_q;
  logic [31:0]       msrc_ns2_q, pre_ns2_q, fin_ns2_q;

  always_ff @(posedge clk_i) begin
    en2_q        <= en1_q;
    mac_fin2_q   <= mac_fin1_q;
    pre_mclks2_q <= pre_mclks1_q;
    req2_q       <= req1_q;
    msrc_ns2_q   <= 32'(32'(msrc_mclks1_q) * 32'(mac_pre1_q)) + RoundHalf;
    pre_ns2_q    <= 32'(32'(pre_mclks1_q) * 32'(mac_pre1_q)) + RoundHalf;
    fin_ns2_q    <= 32'(32'(fin_mclks1_q) * 32'(mac_fin1_q)) + RoundHalf;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide the three sums by 1000 with a reciprocal multiplication.
  // ---------------------------------------------------------------------------
  logic              v3_q;
  logic [7:0]        en3_q;
  logic [MacW-1:0]   mac_fin3_q;
  logic [15:0]       pre_mclks3_q;
  logic [31:0]       req3_q;
  logic [23:0]       msrc_us3_q, pre_us3_q, fin_us3_q;

  logic [63:0] msrc_prod, pre_prod, fin_prod;
  assign msrc_prod = 64'(msrc_ns2_q) * 64'(Recip1000);
  assign pre_prod  = 64'(pre_ns2_q) * 64'(Recip1000);
  assign fin_prod  = 64'(fin_ns2_q) * 64'(Recip1000);

  always_ff @(posedge clk_i) begin
    en3_q        <= en2_q;
    mac_fin3_q   <= mac_fin2_q;
    pre_mclks3_q <= pre_mclks2_q;
    req3_q       <= req2_q;
    msrc_us3_q   <= msrc_prod[63:40];
    pre_us3_q    <= pre_prod[63:40];
    fin_us3_q    <= fin_prod[63:40];
  end

  // ---------------------------------------------------------------------------
  // Stage 4: add up the overheads of the enabled steps. DSS takes precedence
  // over MSRC and counts twice.
  // ---------------------------------------------------------------------------
  logic              v4_q;
  logic [7:0]        en4_q;
  logic [MacW-1:0]   mac_fin4_q;
  logic [15:0]       pre_mclks4_q;
  logic [31:0]       req4_q, cur4_q, used4_q;

  logic [31:0] base_d, msrc_us_w;
  assign msrc_us_w = 32'(msrc_us3_q);

  always_comb begin
    base_d = OvhStart + OvhEnd;
    if (en3_q[4]) begin
      base_d = base_d + msrc_us_w + OvhTcc;
    end
    if (en3_q[3]) begin
      base_d = base_d + 32'((msrc_us_w + OvhDss) << 1);
    end else if (en3_q[2]) begin
      base_d = base_d + msrc_us_w + OvhMsrc;
    end
    if (en3_q[6]) begin
      base_d = base_d + 32'(pre_us3_q) + OvhPre;
    end
  end

  always_ff @(posedge clk_i) begin
    en4_q        <= en3_q;
    mac_fin4_q   <= mac_fin3_q;
    pre_mclks4_q <= pre_mclks3_q;
    req4_q       <= req3_q;
    cur4_q       <= en3_q[7] ? (base_d + 32'(fin_us3_q) + OvhFinal) : base_d;
    used4_q      <= base_d + OvhFinal;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: decide the status and form the dividend of the microsecond to
  // macro clock conversion, (remaining * 1000 + period / 2) mod 2^32.
  // ---------------------------------------------------------------------------
  logic              v5_q;
  logic [31:0]       dividend5_q;
  logic [MacW-1:0]   divisor5_q;
  div_side_t         side5_q;

  logic [31:0] remain_d;
  logic [1:0]  status_d;
  assign remain_d = req4_q - used4_q;

  always_comb begin
    if (!en4_q[7]) begin
      status_d = StatusDisabled;
    end else if (used4_q > req4_q) begin
      status_d = StatusTooSmall;
    end else begin
      status_d = StatusWritten;
    end
  end

  always_ff @(posedge clk_i) begin
    dividend5_q     <= 32'(remain_d * 32'd1000) + 32'(mac_fin4_q[MacW-1:1]);
    divisor5_q      <= mac_fin4_q;
    side5_q.cur     <= cur4_q;
    side5_q.status  <= status_d;
    side5_q.pre_add <= en4_q[6] ? pre_mclks4_q : 16'd0;
  end

  // ---------------------------------------------------------------------------
  // Stages 6 to 37: the divider. A zero period yields an all-ones quotient.
  // ---------------------------------------------------------------------------
  logic        dv_valid;
  logic [31:0] dv_quot;
  div_side_t   dv_side;

  rtbc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v5_q),
    .dividend_i  (dividend5_q),
    .divisor_i   (divisor5_q),
    .side_i      (side5_q),
    .out_valid_o (dv_valid),
    .quotient_o  (dv_quot),
    .side_o      (dv_side)
  );

  // ---------------------------------------------------------------------------
  // Stage 38: add pre-range back, subtract one and find how far the value
  // must be shifted so that it fits an 8-bit mantissa.
  // ---------------------------------------------------------------------------
  logic        va_q;
  logic [31:0] lsb_a_q;
  logic [4:0]  exp_a_q;
  logic        zero_a_q;
  logic [31:0] cur_a_q;
  logic [1:0]  status_a_q;

  logic [31:0] m_d, ls_d;
  logic [4:0]  exp_d;
  assign m_d  = dv_quot + 32'(dv_side.pre_add);
  assign ls_d = m_d - 32'd1;

  // The exponent is the position of the top set bit above bit 7, less 7.
  always_comb begin
    exp_d = 5'd0;
    for (int b = 8; b < WordW; b++) begin
      if (ls_d[b]) exp_d = 5'(b - 7);
    end
  end

  always_ff @(posedge clk_i) begin
    lsb_a_q    <= ls_d;
    exp_a_q    <= exp_d;
    zero_a_q   <= (m_d == 32'd0);
    cur_a_q    <= dv_side.cur;
    status_a_q <= dv_side.status;
  end

  // ---------------------------------------------------------------------------
  // Stage 39: shift down, pack the code and register the result.
  // ---------------------------------------------------------------------------
  logic        done_q;
  result_t     result_q;
  logic [31:0] shifted_d;
  assign shifted_d = lsb_a_q >> exp_a_q;

  always_ff @(posedge clk_i) begin
    result_q.current_budget_us <= cur_a_q;
    result_q.set_status        <= status_a_q;
    if (zero_a_q || (status_a_q != StatusWritten)) begin
      result_q.new_final_code <= 16'd0;
    end else begin
      result_q.new_final_code <= {3'd0, exp_a_q, shifted_d[7:0]};
    end
  end

  // Valid bits of the stages outside the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      va_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= accept;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      va_q   <= dv_valid;
      done_q <= va_q;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

@@ hw/rtl/rtbc_checker.sv @@
// Port-level checker for ranging_timing_budget_calc, bound to the top level below.
// Depends on rtbc_pkg for the item and result types and status codes.
module rtbc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input rtbc_pkg::item_t   item_i,
  input logic              done_o,
  input rtbc_pkg::result_t result_o
);
  import rtbc_pkg::*;

  localparam int unsigned Latency = 39;

  // Every result traces back to a transaction exactly one latency earlier.
  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without a matching transaction");

  // A disabled final range in the transaction must report status disabled.
  a_disabled_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((result_o.set_status == StatusDisabled)
                == !$past(item_i.sequence_enables[7], Latency)))
    else $error("status disagrees with the final-range enable");

  // No code is written unless the status says so.
  a_code_only_when_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.set_status != StatusWritten)) |-> (result_o.new_final_code == 16'd0))
    else $error("timeout code present without a write");

  // The block never pushes back.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !busy)
    else $error("busy raised");

endmodule

bind ranging_timing_budget_calc rtbc_checker u_rtbc_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);

@@ bench/ranging_timing_budget_calc_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ranging_timing_budget_calc: a behavioral budget model predicts each
// result, and a checker compares every done_o strobe with the oldest prediction. Uses rtbc_pkg.
module ranging_timing_budget_calc_tb;
  import rtbc_pkg::*;

  localparam int unsigned Latency  = 39;
  localparam longint      MaxCycles = 400000;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    done_o;
  result_t result_o;

  result_t budget_q[$];
  int      n_errors;
  longint  cycle_cnt;

  ranging_timing_budget_calc dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // 12 ns clock.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Timeout guard. Worst case is every item with its longest gap plus the pipeline drain,
  // far below this limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == MaxCycles) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Pulse period, decoded from the register value and truncated to 8 bits.
  function automatic bit [31:0] pulse_period(bit [7:0] code);
    return 32'(8'(({1'b0, code} + 9'd1) << 1));
  endfunction

  // Macro period in ns, with 32-bit wrapping of the intermediate product.
  function automatic bit [31:0] macro_ns_of(bit [31:0] p);
    bit [31:0] prod;
    prod = 32'd2304 * p * 32'd1655 + 32'd500;
    return prod / 32'd1000;
  endfunction

  function automatic bit [31:0] clocks_to_us(bit [31:0] clocks, bit [31:0] mac);
    bit [31:0] t;
    t = clocks * mac + 32'd500;
    return t / 32'd1000;
  endfunction

  // A zero macro period makes the division return all ones, as a hardware divider does.
  function automatic bit [31:0] us_to_clocks(bit [31:0] us, bit [31:0] mac);
    bit [31:0] t;
    if (mac == 0) return 32'hFFFF_FFFF;
    t = us * 32'd1000 + (mac >> 1);
    return t / mac;
  endfunction

  function automatic bit [31:0] timeout_clocks(bit [15:0] code);
    bit [31:0] v;
    v = (code[15:8] >= 16) ? 32'd0 : ((32'(code[7:0]) << code[15:8]) & 32'hFFFF);
    return (v + 1) & 32'hFFFF;
  endfunction

  // Normalize clocks-1 into an 8-bit mantissa and an exponent.
  function automatic bit [15:0] timeout_code(bit [31:0] clocks);
    bit [31:0] mant;
    bit [31:0] expo;
    if (clocks == 0) return 16'd0;
    mant = clocks - 1;
    expo = 0;
    while ((mant & 32'hFFFF_FF00) != 0) begin
      mant = mant >> 1;
      expo++;
    end
    return 16'((expo << 8) | (mant & 32'hFF));
  endfunction

  function automatic result_t predict_budget(item_t it);
    result_t   r;
    bit        tcc, dss, msrc, pre, fin;
    bit [31:0] mac_pre, mac_fin, msrc_us, pre_clk, pre_us, fin_clk, fin_us;
    bit [31:0] base, used, clk_req;
    tcc  = it.sequence_enables[4];
    dss  = it.sequence_enables[3];
    msrc = it.sequence_enables[2];
    pre  = it.sequence_enables[6];
    fin  = it.sequence_enables[7];
    mac_pre = macro_ns_of(pulse_period(it.pre_period_code));
    mac_fin = macro_ns_of(pulse_period(it.final_period_code));
    msrc_us = clocks_to_us(32'(it.msrc_timeout_code) + 1, mac_pre);
    pre_clk = timeout_clocks(it.pre_timeout_code);
    pre_us  = clocks_to_us(pre_clk, mac_pre);
    fin_clk = timeout_clocks(it.final_timeout_code);
    // The final-range timeout register includes the pre-range part when that is on.
    if (pre) fin_clk = (fin_clk - pre_clk) & 32'hFFFF;
    fin_us = clocks_to_us(fin_clk, mac_fin);
    base = OvhStart + OvhEnd;
    if (tcc) base += msrc_us + OvhTcc;
    if (dss) base += 2 * (msrc_us + OvhDss);
    else if (msrc) base += msrc_us + OvhMsrc;
    if (pre) base += pre_us + OvhPre;
    r.current_budget_us = fin ? base + fin_us + OvhFinal : base;
    r.new_final_code = '0;
    if (!fin) begin
      r.set_status = StatusDisabled;
    end else begin
      used = base + OvhFinal;
      if (used > it.requested_budget_us) begin
        r.set_status = StatusTooSmall;
      end else begin
        clk_req = us_to_clocks(it.requested_budget_us - used, mac_fin);
        if (pre) clk_req += pre_clk;
        r.new_final_code = timeout_code(clk_req);
        r.set_status = StatusWritten;
      end
    end
    return r;
  endfunction

  // Results cannot be held off, so the checker samples every strobe at the rising edge.
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && done_o) begin
      if (budget_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result_o);
        n_errors++;
      end else begin
        exp_r = budget_q.pop_front();
        if (result_o.current_budget_us !== exp_r.current_budget_us) begin
          $display("%0t: current_budget_us expected %h actual %h", $time,
                   exp_r.current_budget_us, result_o.current_budget_us);
          n_errors++;
        end
        if (result_o.new_final_code !== exp_r.new_final_code) begin
          $display("%0t: new_final_code expected %h actual %h", $time,
                   exp_r.new_final_code, result_o.new_final_code);
          n_errors++;
        end
        if (result_o.set_status !== exp_r.set_status) begin
          $display("%0t: set_status expected %h actual %h", $time,
                   exp_r.set_status, result_o.set_status);
          n_errors++;
        end
      end
    end
  end

  // Random gap before an item: mostly none or short, now and then long.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 30);
    repeat (n) @(posedge clk_i);
  endtask

  // Send one transaction: hold start until the block accepts it at an edge with busy low.
  task automatic send_item(item_t it, bit allow_gap = 1'b1);
    if (allow_gap && start) begin
      idle_gap_sent();
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    budget_q.push_back(predict_budget(it));
  endtask

  // Dropping start only if a gap is taken keeps back-to-back runs of items.
  task automatic idle_gap_sent();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 30);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic item_t random_item();
    item_t it;
    it.sequence_enables    = 8'($urandom);
    it.pre_period_code     = 8'($urandom);
    it.final_period_code   = 8'($urandom);
    it.msrc_timeout_code   = 8'($urandom);
    it.pre_timeout_code    = 16'($urandom);
    it.final_timeout_code  = 16'($urandom);
    it.requested_budget_us = $urandom;
    return it;
  endfunction

  // Realistic register values: small even-ish periods, exponents below 16, budgets that
  // mostly fit so that the encode path gets exercised.
  function automatic item_t sensible_item();
    item_t it;
    it = random_item();
    it.pre_period_code    = 8'($urandom_range(5, 9));
    it.final_period_code  = 8'($urandom_range(3, 7));
    it.pre_timeout_code   = {8'($urandom_range(0, 15)), 8'($urandom)};
    it.final_timeout_code = {8'($urandom_range(0, 15)), 8'($urandom)};
    case ($urandom_range(0, 3))
      0: it.requested_budget_us = $urandom_range(20000, 200000);
      1: it.requested_budget_us = $urandom_range(0, 20000);
      2: it.requested_budget_us = $urandom_range(200000, 5000000);
      default: it.requested_budget_us = $urandom;
    endcase
    return it;
  endfunction

  task automatic test_field_extremes();
    item_t it;
    it = '0;
    send_item(it);
    send_item('1);
    it = '1;
    it.sequence_enables = 8'h80;
    send_item(it);
    it = '0;
    it.sequence_enables    = 8'hDC;
    it.requested_budget_us = 32'hFFFF_FFFF;
    send_item(it);
  endtask

  task automatic test_step_enables();
    item_t it;
    for (int k = 0; k < 8; k++) begin
      it = sensible_item();
      it.sequence_enables    = {1'b1, k[2], 1'b0, k[1], k[0], $urandom_range(0, 1) ? 1'b1 : 1'b0,
                                2'b00};
      it.requested_budget_us = 32'd33000;
      send_item(it);
    end
  endtask

  task automatic test_special_cases();
    item_t it;
    // Final range disabled.
    it = sensible_item();
    it.sequence_enables = 8'h5C;
    send_item(it);
    // Budget too small.
    it = sensible_item();
    it.sequence_enables    = 8'hDC;
    it.requested_budget_us = 32'd1000;
    send_item(it);
    // Zero computed timeout: request leaves nothing and pre-range is off.
    it = sensible_item();
    it.sequence_enables    = 8'h80;
    it.requested_budget_us = OvhStart + OvhEnd + OvhFinal;
    send_item(it);
    // Large exponent on both timeouts.
    it = sensible_item();
    it.sequence_enables   = 8'hC0;
    it.pre_timeout_code   = 16'h10FF;
    it.final_timeout_code = 16'hFF12;
    send_item(it);
    // Pre-range larger than final.
    it = sensible_item();
    it.sequence_enables   = 8'hC0;
    it.pre_timeout_code   = 16'h0AFF;
    it.final_timeout_code = 16'h0010;
    send_item(it);
    // Zero final period from both codes that wrap to it.
    it = sensible_item();
    it.sequence_enables  = 8'hD4;
    it.final_period_code = 8'd127;
    send_item(it);
    it.final_period_code = 8'd255;
    it.sequence_enables  = 8'h80;
    send_item(it);
  endtask

  task automatic test_random_items(int count);
    for (int k = 0; k < count; k++) begin
      send_item(($urandom_range(0, 9) < 7) ? sensible_item() : random_item());
    end
  endtask

  initial begin
    n_errors  = 0;
    cycle_cnt = 0;
    start     = 1'b0;
    item_i    = '0;
    rst_ni    = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_step_enables();
    test_special_cases();
    test_random_items(450);
    start <= 1'b0;

    while (budget_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
